>>> rtl/core/tuidg_pkg.sv
// Shared types and constants for the timestamp unique-ID generator.
// No dependencies; the core files that use it refer to it by scoped names.
package tuidg_pkg;

    // field widths
    localparam int NOW_W      = 63;
    localparam int TICK_W     = 40;
    localparam int MID_W      = 16;
    localparam int ID_W       = 64;
    localparam int WAIT_W     = 32;
    localparam int START_W    = 40;
    localparam int START_US_W = 60;   // start_seconds * 1e6 fits in 60 bits
    localparam int IDCNT_W    = 3;

    // APB side
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int REG_SEL_LSB = 3;   // 8-byte register stride
    localparam int NUM_MID_REGS = 4;

    typedef enum logic [2:0] {
        REG_START_SECONDS = 3'd0,
        REG_ID_COUNT      = 3'd1,
        REG_MACHINE_ID_0  = 3'd2,
        REG_MACHINE_ID_1  = 3'd3,
        REG_MACHINE_ID_2  = 3'd4,
        REG_MACHINE_ID_3  = 3'd5
    } t_reg_idx;

    localparam logic [START_W-1:0]    START_SECONDS_RESET = 40'd1409529600;
    localparam logic [IDCNT_W-1:0]    ID_COUNT_RESET      = 3'd1;
    localparam logic [19:0]           US_PER_SEC          = 20'd1000000;
    localparam logic [13:0]           US_PER_TICK         = 14'd10000;
    localparam logic [START_US_W-1:0] START_US_RESET =
        60'(START_SECONDS_RESET) * 60'(US_PER_SEC);

    // Tick division: 10000 = 16 * 625. The shifted dividend is split into
    // 10-bit digits, one digit per pipeline stage, remainder always < 625.
    localparam int DIV_PRE     = 4;
    localparam int DIV_CHUNK   = 10;
    localparam int DIV_STEPS   = 6;
    localparam int DIV_W       = DIV_STEPS * DIV_CHUNK;   // 60 >= 59 dividend bits
    localparam int DIV_V_W     = 2 * DIV_CHUNK;
    localparam int DIV_SHIFT   = 30;
    localparam int DIV_PROD_W  = 41;
    localparam logic [DIV_V_W-1:0]  DIV_DEN   = 20'd625;
    localparam logic [20:0]         DIV_RECIP = 21'd1717987;   // ceil(2^30 / 625)

    localparam int FUT_W = TICK_W + 14;   // tick * 10000

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [NOW_W-1:0]  diff;
    } t_tick_item;

    typedef struct packed {
        logic [ID_W-1:0]   unique_id;
        logic [WAIT_W-1:0] wait_us;
    } t_result;

endpackage

>>> rtl/core/tuidg_fifo.sv
// Small first-word-fall-through queue built from a register array.
// Generic payload width; no package dependency. Caller never pushes when full.
module tuidg_fifo #(
    parameter int DEPTH = 4,
    parameter int W     = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

endmodule

>>> rtl/core/tuidg_regs.sv
// APB configuration registers: epoch start, ID count and machine-ID table.
// Uses tuidg_pkg. Keeps start time pre-scaled to microseconds for the front end.
module tuidg_regs #(
    parameter int MAX_IDS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tuidg_pkg::ADDR_W-1:0]        paddr,
    input  logic [tuidg_pkg::DATA_W-1:0]        pwdata,
    output logic [tuidg_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    output logic [tuidg_pkg::START_US_W-1:0]    o_start_us,
    output logic [tuidg_pkg::IDCNT_W-1:0]       o_id_count,
    output logic [tuidg_pkg::MID_W-1:0]         o_mid [MAX_IDS]
);
    logic [2:0]                           idx;
    logic                                 wr;
    logic [tuidg_pkg::START_W-1:0]        r_start_seconds;
    logic [tuidg_pkg::START_US_W-1:0]     r_start_us;
    logic [tuidg_pkg::IDCNT_W-1:0]        r_id_count;
    logic [tuidg_pkg::MID_W-1:0]          r_mid [MAX_IDS];
    logic [tuidg_pkg::START_US_W-1:0]     start_us_new;

    assign idx    = paddr[tuidg_pkg::ADDR_W-1:tuidg_pkg::REG_SEL_LSB];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    // constant multiply of the write data, captured only on a start-seconds write
    assign start_us_new = tuidg_pkg::START_US_W'(pwdata[tuidg_pkg::START_W-1:0])
                        * tuidg_pkg::START_US_W'(tuidg_pkg::US_PER_SEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_seconds <= tuidg_pkg::START_SECONDS_RESET;
            r_start_us      <= tuidg_pkg::START_US_RESET;
            r_id_count      <= tuidg_pkg::ID_COUNT_RESET;
            for (int j = 0; j < MAX_IDS; j++) begin
                r_mid[j] <= '0;
            end
        end else if (wr) begin
            case (idx)
                tuidg_pkg::REG_START_SECONDS: begin
                    r_start_seconds <= pwdata[tuidg_pkg::START_W-1:0];
                    r_start_us      <= start_us_new;
                end
                tuidg_pkg::REG_ID_COUNT: begin
                    r_id_count <= pwdata[tuidg_pkg::IDCNT_W-1:0];
                end
                default: begin
                end
            endcase
            // table entries past MAX_IDS have no storage, writes drop
            for (int j = 0; j < MAX_IDS; j++) begin
                if (j < tuidg_pkg::NUM_MID_REGS &&
                    idx == 3'(tuidg_pkg::REG_MACHINE_ID_0) + 3'(j)) begin
                    r_mid[j] <= pwdata[tuidg_pkg::MID_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            tuidg_pkg::REG_START_SECONDS: prdata = tuidg_pkg::DATA_W'(r_start_seconds);
            tuidg_pkg::REG_ID_COUNT:      prdata = tuidg_pkg::DATA_W'(r_id_count);
            default:                      prdata = '0;
        endcase
        for (int j = 0; j < MAX_IDS; j++) begin
            if (j < tuidg_pkg::NUM_MID_REGS &&
                idx == 3'(tuidg_pkg::REG_MACHINE_ID_0) + 3'(j)) begin
                prdata = tuidg_pkg::DATA_W'(r_mid[j]);
            end
        end
    end

    assign o_start_us = r_start_us;
    assign o_id_count = r_id_count;
    always_comb begin
        for (int j = 0; j < MAX_IDS; j++) begin
            o_mid[j] = r_mid[j];
        end
    end

endmodule

>>> rtl/core/tuidg_front.sv
// Front end: takes requests, subtracts the epoch start and converts to 10 ms
// ticks in a digit-per-stage divider. Uses tuidg_pkg. Credit count drives full.
module tuidg_front #(
    parameter int MQ_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [tuidg_pkg::NOW_W-1:0]         i_now_us,
    input  logic [tuidg_pkg::START_US_W-1:0]    i_start_us,
    input  logic                                i_release,
    output logic                                o_full,
    output logic                                o_valid,
    output tuidg_pkg::t_tick_item               o_item
);
    localparam int CR_W  = $clog2(MQ_DEPTH + 1);
    localparam int NS    = tuidg_pkg::DIV_STEPS;
    localparam int CH    = tuidg_pkg::DIV_CHUNK;
    localparam int DW    = tuidg_pkg::DIV_W;

    logic [CR_W-1:0]                  r_credit;
    logic                             r_vld  [NS+1];
    logic [tuidg_pkg::NOW_W-1:0]      r_diff [NS+1];
    logic [CH-1:0]                    r_rem  [NS+1];
    logic [DW-1:0]                    r_quot [NS+1];

    logic [tuidg_pkg::NOW_W-1:0]      start_ext;
    logic [tuidg_pkg::NOW_W-1:0]      diff_in;
    logic [CH-1:0]                    c_q   [NS];
    logic [CH-1:0]                    c_rem [NS];
    logic [DW-1:0]                    fin_quot;

    // requests in the divider plus entries parked in the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CR_W'(i_accept) - CR_W'(i_release);
        end
    end
    assign o_full = (r_credit >= CR_W'(MQ_DEPTH));

    assign start_ext = tuidg_pkg::NOW_W'(i_start_us);
    assign diff_in   = (i_now_us > start_ext) ? (i_now_us - start_ext) : '0;

    // one quotient digit per stage; v < 625*1024
    always_comb begin
        logic [DW-1:0]                    xpad;
        logic [tuidg_pkg::DIV_V_W-1:0]    v;
        logic [tuidg_pkg::DIV_PROD_W-1:0] prod;
        logic [tuidg_pkg::DIV_V_W-1:0]    qd;
        for (int k = 0; k < NS; k++) begin
            xpad = DW'(r_diff[k][tuidg_pkg::NOW_W-1:tuidg_pkg::DIV_PRE]);
            v    = {r_rem[k], xpad[DW-1-CH*k -: CH]};
            prod = tuidg_pkg::DIV_PROD_W'(v) * tuidg_pkg::DIV_PROD_W'(tuidg_pkg::DIV_RECIP);
            c_q[k] = prod[tuidg_pkg::DIV_SHIFT+CH-1:tuidg_pkg::DIV_SHIFT];
            qd     = tuidg_pkg::DIV_V_W'(c_q[k]) * tuidg_pkg::DIV_DEN;
            c_rem[k] = CH'(v - qd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_accept;
            for (int k = 0; k < NS; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff[0] <= diff_in;
        r_rem[0]  <= '0;
        r_quot[0] <= '0;
        for (int k = 0; k < NS; k++) begin
            r_diff[k+1] <= r_diff[k];
            r_rem[k+1]  <= c_rem[k];
            r_quot[k+1] <= {r_quot[k][DW-CH-1:0], c_q[k]};
        end
    end

    assign fin_quot    = r_quot[NS];
    assign o_valid     = r_vld[NS];
    assign o_item.diff = r_diff[NS];
    assign o_item.tick = (|fin_quot[DW-1:tuidg_pkg::TICK_W]) ? '1
                       : fin_quot[tuidg_pkg::TICK_W-1:0];

endmodule

>>> rtl/core/tuidg_back.sv
// Back end: holds elapsed tick and sequence position, builds the ID and the
// wait time. Uses tuidg_pkg. Pulls from the tick queue while output credit lasts.
module tuidg_back #(
    parameter int MAX_IDS  = 4,
    parameter int SEQ_BITS = 8,
    parameter int OQ_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_mq_empty,
    input  tuidg_pkg::t_tick_item           i_mq_item,
    output logic                            o_mq_pop,
    input  logic [tuidg_pkg::IDCNT_W-1:0]   i_id_count,
    input  logic [tuidg_pkg::MID_W-1:0]     i_mid [MAX_IDS],
    output logic                            o_push,
    output tuidg_pkg::t_result              o_result,
    input  logic                            i_out_pop
);
    localparam int SLOT_W    = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int POS_W     = SLOT_W + SEQ_BITS;
    localparam int CNT_W     = SLOT_W + 1;
    localparam int ID_FULL_W = tuidg_pkg::TICK_W + tuidg_pkg::MID_W + SEQ_BITS;
    localparam int CR_W      = $clog2(OQ_DEPTH + 1);
    localparam int TW        = tuidg_pkg::TICK_W;
    localparam int NW        = tuidg_pkg::NOW_W;

    function automatic logic [CNT_W-1:0] f_slot_mod(input logic [CNT_W-1:0] s,
                                                    input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        r = s;
        for (int k = 0; k < MAX_IDS; k++) begin
            if (r >= n) begin
                r = r - n;
            end
        end
        return r;
    endfunction

    logic [TW-1:0]              r_elapsed;
    logic [POS_W-1:0]           r_pos;
    logic [CR_W-1:0]            r_credit;

    logic                       r_b1_valid;
    logic [tuidg_pkg::ID_W-1:0] r_b1_id;
    logic                       r_b1_wrap;
    logic [TW-1:0]              r_b1_elapsed;
    logic [NW-1:0]              r_b1_diff;

    logic                       r_b2_valid;
    logic [tuidg_pkg::ID_W-1:0] r_b2_id;
    logic                       r_b2_wrap;
    logic [tuidg_pkg::FUT_W-1:0] r_b2_future;
    logic [NW-1:0]              r_b2_diff;

    logic                       take;
    logic [tuidg_pkg::IDCNT_W-1:0] ids3;
    logic [CNT_W-1:0]           ids;
    logic [POS_W:0]             pos_inc;
    logic [CNT_W-1:0]           slot_mod;
    logic [POS_W-1:0]           pos_step;
    logic                       advance;
    logic                       wrap;
    logic [TW-1:0]              n_elapsed;
    logic [POS_W-1:0]           n_pos;
    logic [SLOT_W-1:0]          slot;
    logic [tuidg_pkg::MID_W-1:0] mid;
    logic [ID_FULL_W-1:0]       id_full;
    logic [NW-1:0]              fut_ext;
    logic [NW-1:0]              dlt;
    logic [tuidg_pkg::WAIT_W-1:0] wait_val;

    assign take     = !i_mq_empty && (r_credit < CR_W'(OQ_DEPTH));
    assign o_mq_pop = take;

    assign ids3 = (i_id_count == '0) ? tuidg_pkg::IDCNT_W'(1)
                : (i_id_count > tuidg_pkg::IDCNT_W'(MAX_IDS)) ? tuidg_pkg::IDCNT_W'(MAX_IDS)
                : i_id_count;
    assign ids  = CNT_W'(ids3);

    // modulo over (ids << SEQ_BITS) only touches the slot part
    assign pos_inc  = {1'b0, r_pos} + 1'b1;
    assign slot_mod = f_slot_mod(pos_inc[POS_W:SEQ_BITS], ids);
    assign pos_step = {slot_mod[SLOT_W-1:0], pos_inc[SEQ_BITS-1:0]};

    assign advance = (r_elapsed < i_mq_item.tick);
    assign wrap    = !advance && (pos_step == '0);

    assign n_elapsed = advance ? i_mq_item.tick
                     : wrap ? r_elapsed + 1'b1
                     : r_elapsed;
    assign n_pos     = advance ? '0 : pos_step;

    assign slot = n_pos[POS_W-1:SEQ_BITS];
    assign mid  = ({1'b0, slot} < CNT_W'(MAX_IDS)) ? i_mid[slot] : '0;
    assign id_full = {n_elapsed, mid, n_pos[SEQ_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed  <= '0;
            r_pos      <= '0;
            r_credit   <= '0;
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
        end else begin
            if (take) begin
                r_elapsed <= n_elapsed;
                r_pos     <= n_pos;
            end
            r_credit   <= r_credit + CR_W'(take) - CR_W'(i_out_pop);
            r_b1_valid <= take;
            r_b2_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_id      <= tuidg_pkg::ID_W'(id_full);
        r_b1_wrap    <= wrap;
        r_b1_elapsed <= n_elapsed;
        r_b1_diff    <= i_mq_item.diff;

        r_b2_id      <= r_b1_id;
        r_b2_wrap    <= r_b1_wrap;
        r_b2_future  <= tuidg_pkg::FUT_W'(r_b1_elapsed)
                      * tuidg_pkg::FUT_W'(tuidg_pkg::US_PER_TICK);
        r_b2_diff    <= r_b1_diff;
    end

    // time until the bumped tick, only after a wrap, saturating
    assign fut_ext = NW'(r_b2_future);
    assign dlt     = fut_ext - r_b2_diff;
    always_comb begin
        wait_val = '0;
        if (r_b2_wrap && (fut_ext > r_b2_diff)) begin
            wait_val = (|dlt[NW-1:tuidg_pkg::WAIT_W]) ? '1 : dlt[tuidg_pkg::WAIT_W-1:0];
        end
    end

    assign o_push             = r_b2_valid;
    assign o_result.unique_id = r_b2_id;
    assign o_result.wait_us   = wait_val;

endmodule

>>> rtl/core/timestamp_unique_id_generator.sv
// Timestamp unique-ID generator: one request in, one 64-bit ID plus wait time out.
// Sustains one request per cycle while full is low. A request passes the front
// end (the epoch subtract register, then the 10 ms tick divider, one 10-bit digit
// per stage), a MQ_DEPTH-entry queue, then the back end (state update register,
// then the tick-to-microsecond multiply register) before it lands in an
// OQ_DEPTH-entry result queue. The combinational compare and increment on the
// elapsed tick and sequence position sets the rate. full is a credit count over
// the front end plus its queue, so it can rise while the back end is still
// draining.
// Depends on tuidg_pkg, tuidg_regs, tuidg_front, tuidg_back and tuidg_fifo.
module timestamp_unique_id_generator #(
    parameter int MAX_IDS  = 4,
    parameter int SEQ_BITS = 8,
    parameter int MQ_DEPTH = 16,
    parameter int OQ_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [tuidg_pkg::NOW_W-1:0]     i_now_us,
    output logic                            empty,
    input  logic                            pop,
    output logic [tuidg_pkg::ID_W-1:0]      o_unique_id,
    output logic [tuidg_pkg::WAIT_W-1:0]    o_wait_us,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tuidg_pkg::ADDR_W-1:0]    paddr,
    input  logic [tuidg_pkg::DATA_W-1:0]    pwdata,
    output logic [tuidg_pkg::DATA_W-1:0]    prdata,
    output logic                            pready
);
    logic                                accept;
    logic                                out_pop;
    logic [tuidg_pkg::START_US_W-1:0]    start_us;
    logic [tuidg_pkg::IDCNT_W-1:0]       id_count;
    logic [tuidg_pkg::MID_W-1:0]         mid_tbl [MAX_IDS];
    logic                                fe_valid;
    tuidg_pkg::t_tick_item               fe_item;
    logic                                mq_empty;
    logic                                mq_pop;
    tuidg_pkg::t_tick_item               mq_item;
    logic                                be_push;
    tuidg_pkg::t_result                  be_result;
    tuidg_pkg::t_result                  oq_result;

    assign accept  = push && !full;
    assign out_pop = pop && !empty;

    tuidg_regs #(
        .MAX_IDS (MAX_IDS)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_start_us (start_us),
        .o_id_count (id_count),
        .o_mid      (mid_tbl)
    );

    tuidg_front #(
        .MQ_DEPTH (MQ_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_now_us   (i_now_us),
        .i_start_us (start_us),
        .i_release  (mq_pop),
        .o_full     (full),
        .o_valid    (fe_valid),
        .o_item     (fe_item)
    );

    tuidg_fifo #(
        .DEPTH (MQ_DEPTH),
        .W     ($bits(tuidg_pkg::t_tick_item))
    ) u_tick_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid),
        .i_wdata (fe_item),
        .i_pop   (mq_pop),
        .o_empty (mq_empty),
        .o_rdata (mq_item)
    );

    tuidg_back #(
        .MAX_IDS  (MAX_IDS),
        .SEQ_BITS (SEQ_BITS),
        .OQ_DEPTH (OQ_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mq_empty (mq_empty),
        .i_mq_item  (mq_item),
        .o_mq_pop   (mq_pop),
        .i_id_count (id_count),
        .i_mid      (mid_tbl),
        .o_push     (be_push),
        .o_result   (be_result),
        .i_out_pop  (out_pop)
    );

    tuidg_fifo #(
        .DEPTH (OQ_DEPTH),
        .W     ($bits(tuidg_pkg::t_result))
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (be_push),
        .i_wdata (be_result),
        .i_pop   (out_pop),
        .o_empty (empty),
        .o_rdata (oq_result)
    );

    assign o_unique_id = oq_result.unique_id;
    assign o_wait_us   = oq_result.wait_us;

endmodule

>>> rtl/core/tuidg_checker.sv
// Port-level checks for the timestamp unique-ID generator, bound to the top.
// Uses only top-level ports; no package dependency.
module tuidg_checker #(
    parameter int SEQ_BITS = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_push,
    input logic        i_full,
    input logic        i_empty,
    input logic        i_pop,
    input logic [63:0] i_unique_id,
    input logic [31:0] i_wait_us,
    input logic        i_pready
);

    // queues come out of reset drained with space for requests
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> i_empty && !i_full)
        else $error("result pending or full right after reset");

    // a waiting result stays put until popped
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && !i_pop |=> !i_empty && $stable(i_unique_id) && $stable(i_wait_us))
        else $error("waiting result changed before pop");

    // a nonzero wait only follows a wrap, which restarts the sequence at zero
    a_wait_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && (i_wait_us != 32'd0) |-> (i_unique_id[SEQ_BITS-1:0] == '0))
        else $error("wait reported with nonzero sequence number");

    // full only rises after a request went in
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_full) |-> $past(i_push && !i_full))
        else $error("full rose without an accepted request");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind timestamp_unique_id_generator tuidg_checker #(
    .SEQ_BITS (SEQ_BITS)
) u_tuidg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_push      (push),
    .i_full      (full),
    .i_empty     (empty),
    .i_pop       (pop),
    .i_unique_id (o_unique_id),
    .i_wait_us   (o_wait_us),
    .i_pready    (pready)
);

>>> tb/timestamp_unique_id_generator_tb.sv
// Self-checking testbench for timestamp_unique_id_generator: directed table, then random
// ID requests checked against a behavioral model of the tick and sequence state.
// Depends on tuidg_pkg and the timestamp_unique_id_generator RTL.
`timescale 1ns / 1ps

module timestamp_unique_id_generator_tb;

    import tuidg_pkg::*;

    localparam int MAX_IDS      = 4;
    localparam int SEQ_BITS     = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 1000000;

    localparam logic [NOW_W-1:0]   NOW_MAX   = '1;
    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
    localparam logic [START_W-1:0] START_MAX = '1;
    localparam logic [2:0]         REG_SPARE_A = 3'd6;
    localparam logic [2:0]         REG_SPARE_B = 3'd7;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e         kind;
        logic [2:0]        reg_idx;
        logic [63:0]       value;
        logic [NOW_W-1:0]  now;
        bit                typed;
        logic [ID_W-1:0]   exp_id;
        logic [WAIT_W-1:0] exp_wait;
    } dir_row_t;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push    = 1'b0;
    logic                full;
    logic [NOW_W-1:0]    i_now_us = '0;
    logic                empty;
    logic                pop     = 1'b0;
    logic [ID_W-1:0]     o_unique_id;
    logic [WAIT_W-1:0]   o_wait_us;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // model copy of configuration and generator state
    logic [START_W-1:0]  cfg_start;
    logic [2:0]          cfg_idcnt;
    logic [MID_W-1:0]    cfg_mid [MAX_IDS];
    logic [TICK_W-1:0]   gen_elapsed;
    logic [9:0]          gen_seqpos;

    t_result   pending_ids [$];
    t_result   head_id;
    int        errors     = 0;
    int        cycles     = 0;
    bit        tx_eager   = 0;
    bit        rx_eager   = 0;
    bit        hold_req   = 0;
    int        hold_left  = 0;
    int        rx_gap     = 0;
    logic [63:0] t_cur    = '0;

    dir_row_t directed_rows [0:24] = '{
        '{ROW_REQ, REG_START_SECONDS, 64'd0, 63'd0, 1'b1, 64'h1, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, 63'd0, 1'b1, 64'h2, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, 63'(START_US_RESET), 1'b1, 64'h3, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, 63'(START_US_RESET) + 63'd9999, 1'b1,
          64'h4, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, 63'(START_US_RESET) + 63'd10000, 1'b1,
          64'h0000_0000_0100_0000, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, NOW_MAX, 1'b1, 64'hFFFF_FFFF_FF00_0000, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, NOW_MAX, 1'b1, 64'hFFFF_FFFF_FF00_0001, 32'd0},
        '{ROW_CFG, REG_ID_COUNT, 64'hFFFF_FFFF_FFFF_FFFA, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_MACHINE_ID_0, 64'h0000_0000_0000_FFFF, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_MACHINE_ID_1, 64'hA5A5_A5A5_A5A5_1234, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, NOW_MAX, 1'b1, 64'hFFFF_FFFF_FFFF_FF02, 32'd0},
        '{ROW_CFG, REG_ID_COUNT, 64'd0, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, NOW_MAX, 1'b1, 64'hFFFF_FFFF_FFFF_FF03, 32'd0},
        '{ROW_CFG, REG_START_SECONDS, 64'hFFFF_FFFF_FFFF_FFFF, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, 63'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FF04, 32'd0},
        '{ROW_CFG, REG_START_SECONDS, 64'd0, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, 63'd1, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_ID_COUNT, 64'd7, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_MACHINE_ID_2, 64'hFFFF, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_MACHINE_ID_3, 64'h8001, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_REQ, REG_START_SECONDS, 64'd0, 63'd20000, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_ID_COUNT, 64'd1, 63'd0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_START_SECONDS, 64'(START_SECONDS_RESET), 63'd0, 1'b0, 64'd0, 32'd0}
    };

    timestamp_unique_id_generator #(
        .MAX_IDS  (MAX_IDS),
        .SEQ_BITS (SEQ_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_now_us    (i_now_us),
        .empty       (empty),
        .pop         (pop),
        .o_unique_id (o_unique_id),
        .o_wait_us   (o_wait_us),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic int ids_live();
        if (cfg_idcnt == 3'd0) return 1;
        if (int'(cfg_idcnt) > MAX_IDS) return MAX_IDS;
        return int'(cfg_idcnt);
    endfunction

    // Advances the tick/sequence state for one request and returns the ID it yields.
    function automatic t_result compute_next_id(input logic [NOW_W-1:0] now);
        logic [63:0] start_us, diff, tick, fut, wt;
        int unsigned pos;
        t_result r;
        start_us = 64'(cfg_start) * 64'(US_PER_SEC);
        diff = (64'(now) > start_us) ? 64'(now) - start_us : 64'd0;
        tick = diff / 64'(US_PER_TICK);
        if (tick > 64'(TICK_MAX)) tick = 64'(TICK_MAX);
        wt = '0;
        if (64'(gen_elapsed) < tick) begin
            gen_elapsed = tick[TICK_W-1:0];
            gen_seqpos  = '0;
        end else begin
            pos = (int'(gen_seqpos) + 1) % (ids_live() << SEQ_BITS);
            gen_seqpos = pos[9:0];
            if (pos == 0) begin
                gen_elapsed = gen_elapsed + 1'b1;   // wraps at 40 bits
                fut = 64'(gen_elapsed) * 64'(US_PER_TICK);
                if (fut > diff) begin
                    wt = fut - diff;
                    if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
                end
            end
        end
        r.unique_id = {gen_elapsed, cfg_mid[gen_seqpos >> SEQ_BITS], gen_seqpos[SEQ_BITS-1:0]};
        r.wait_us   = wt[WAIT_W-1:0];
        return r;
    endfunction

    function automatic int draw_idle(input bit eager);
        int r;
        if (eager) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_req(input logic [NOW_W-1:0] now, input bit use_typed,
                            input t_result typed);
        t_result predicted;
        int idle;
        push     <= 1'b1;
        i_now_us <= now;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predicted = compute_next_id(now);
        pending_ids.push_back(use_typed ? typed : predicted);
        idle = draw_idle(tx_eager);
        if (idle > 0) begin
            push <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
    endtask

    task automatic drain_ids();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_ids.size() != 0);
    endtask

    // Register write while idle, then read back the stored value of a defined register.
    task automatic program_reg(input logic [2:0] idx, input logic [63:0] value);
        logic [63:0] want;
        drain_ids();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << REG_SEL_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_START_SECONDS: cfg_start = value[START_W-1:0];
            REG_ID_COUNT:      cfg_idcnt = value[2:0];
            REG_MACHINE_ID_0, REG_MACHINE_ID_1, REG_MACHINE_ID_2, REG_MACHINE_ID_3:
                cfg_mid[idx - REG_MACHINE_ID_0] = value[MID_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        if (idx <= REG_MACHINE_ID_3) begin
            case (idx)
                REG_START_SECONDS: want = 64'(cfg_start);
                REG_ID_COUNT:      want = 64'(cfg_idcnt);
                default:           want = 64'(cfg_mid[idx - REG_MACHINE_ID_0]);
            endcase
            psel   <= 1'b1;
            pwrite <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            if (prdata !== want) note_mismatch("register readback", prdata, want);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int n_items);
        int sent, len, mode, k;
        logic [63:0] start_us, target, rem;
        sent = 0;
        start_us = 64'(cfg_start) * 64'(US_PER_SEC);
        while (sent < n_items) begin
            mode     = $urandom_range(0, 99);
            tx_eager = ($urandom_range(0, 7) == 0);
            rx_eager = ($urandom_range(0, 7) == 0);
            if (mode < 52) begin
                // realistic traffic: several requests per 10 ms tick
                len = $urandom_range(1, 30);
                for (k = 0; k < len; k++) begin
                    t_cur = t_cur + 64'($urandom_range(0, 2999));
                    send_req(t_cur[NOW_W-1:0], 1'b0, '0);
                end
            end else if (mode < 56) begin
                // same-tick requests around the count that wraps the sequence
                len = (ids_live() << SEQ_BITS) + $urandom_range(0, 40) - 20;
                target = $urandom_range(0, 1) ? 64'(NOW_MAX) : t_cur;
                for (k = 0; k < len; k++) send_req(target[NOW_W-1:0], 1'b0, '0);
            end else if (mode < 66) begin
                len = $urandom_range(1, 10);
                for (k = 0; k < len; k++) begin
                    target = (start_us != 0) ? {$urandom, $urandom} % start_us : 64'd0;
                    send_req(target[NOW_W-1:0], 1'b0, '0);
                end
            end else if (mode < 74) begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++) begin
                    target = {$urandom, $urandom};
                    send_req(target[NOW_W-1:0], 1'b0, '0);
                end
            end else if (mode < 80) begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++) send_req(NOW_MAX, 1'b0, '0);
            end else if (mode < 88) begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) begin
                    rem = 64'($urandom_range(0, 200000));
                    target = (t_cur > rem) ? t_cur - rem : 64'd0;
                    send_req(target[NOW_W-1:0], 1'b0, '0);
                end
            end else if (mode < 94) begin
                // last microsecond of a tick, then the first of the next
                rem = (t_cur - start_us) % 64'(US_PER_TICK);
                t_cur = t_cur - rem + 64'(US_PER_TICK) - 64'd1;
                send_req(t_cur[NOW_W-1:0], 1'b0, '0);
                t_cur = t_cur + 64'd1;
                send_req(t_cur[NOW_W-1:0], 1'b0, '0);
                len = 2;
            end else if (mode < 96) begin
                drain_ids();
                len = 0;
            end else begin
                t_cur = t_cur + 64'($urandom);
                send_req(t_cur[NOW_W-1:0], 1'b0, '0);
                len = 1;
            end
            sent += len;
        end
    endtask

    // result side: random stalls, long hold on request, compare against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pending_ids.size() == 0) begin
                    note_mismatch("result with no request pending", o_unique_id, 64'd0);
                end else begin
                    head_id = pending_ids.pop_front();
                    if (o_unique_id !== head_id.unique_id)
                        note_mismatch("unique_id", o_unique_id, head_id.unique_id);
                    if (o_wait_us !== head_id.wait_us)
                        note_mismatch("wait_us", 64'(o_wait_us), 64'(head_id.wait_us));
                end
                rx_gap = draw_idle(rx_eager);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int r, p, m;
        logic [START_W-1:0] st, prev_st;
        logic [2:0] cnt;
        logic [63:0] mid;
        t_result typed;

        cfg_start   = START_SECONDS_RESET;
        cfg_idcnt   = ID_COUNT_RESET;
        for (m = 0; m < MAX_IDS; m++) cfg_mid[m] = '0;
        gen_elapsed = '0;
        gen_seqpos  = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < 25; r++) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                program_reg(directed_rows[r].reg_idx, directed_rows[r].value);
            end else begin
                typed.unique_id = directed_rows[r].exp_id;
                typed.wait_us   = directed_rows[r].exp_wait;
                send_req(directed_rows[r].now, directed_rows[r].typed, typed);
            end
        end

        prev_st = cfg_start;
        t_cur = 64'(cfg_start) * 64'(US_PER_SEC) + 64'($urandom) * 64'd100000;
        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin st = '0;                  cnt = 3'd1; end
                1: begin st = START_MAX;           cnt = 3'd2; end
                2: begin st = START_SECONDS_RESET; cnt = 3'd4; end
                3: begin st = START_SECONDS_RESET; cnt = 3'd1; end
                4: begin st = START_SECONDS_RESET; cnt = 3'd0; end
                5: begin st = {8'($urandom_range(0, 255)), 32'($urandom)}; cnt = 3'd5; end
                6: begin st = 40'($urandom_range(1000000000, 2000000000)); cnt = 3'd7; end
                default: begin st = START_SECONDS_RESET; cnt = 3'd3; end
            endcase
            program_reg(REG_START_SECONDS, {24'($urandom), st});
            program_reg(REG_ID_COUNT, {32'($urandom), 29'($urandom), cnt});
            for (m = 0; m < MAX_IDS; m++) begin
                mid = {$urandom, $urandom};
                if (p == 0) mid[MID_W-1:0] = '0;
                if (p == 1) mid[MID_W-1:0] = '1;
                program_reg(3'(REG_MACHINE_ID_0 + m), mid);
            end
            if (p == 4) begin
                program_reg(REG_SPARE_A, {$urandom, $urandom});
                program_reg(REG_SPARE_B, {$urandom, $urandom});
            end
            if (st != prev_st)
                t_cur = 64'(st) * 64'(US_PER_SEC) + 64'($urandom) * 64'd100000;
            prev_st = st;
            // id_count just shrank: next same-tick request must reduce the position
            if (p == 3) send_req(NOW_MAX, 1'b0, '0);
            if (p == 2 || p == 7) begin
                hold_req = 1'b1;
                tx_eager = 1'b1;
                repeat (40) send_req(t_cur[NOW_W-1:0], 1'b0, '0);
            end
            run_phase(200);
            // leave the position past the range that the next phase allows
            if (p == 2) begin
                tx_eager = 1'b0;
                repeat (700) send_req(NOW_MAX, 1'b0, '0);
            end
        end

        drain_ids();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
